>>> hw/rtl/jss_pkg.sv
// ============================================================================
// jss_pkg : shared constants and types for the Jacobi stencil sweep core
// Field widths, register indexes and reset values of the configuration port.
// ============================================================================
`default_nettype none

package jss_pkg;

  // Fixed field widths
  localparam int DATA_W     = 32;   // Q16.16 grid and source values
  localparam int H_W        = 32;   // h_product, unsigned Q0.32
  localparam int COL_W      = 11;   // cols register / column position
  localparam int ROW_W      = 13;   // rows register / row position
  localparam int OUT_ROW_W  = 12;
  localparam int OUT_COL_W  = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Defaults and limits
  localparam int MAX_COLS_DEF = 1024;
  localparam int ROW_LIMIT    = 4096;

  localparam logic [COL_W-1:0] COLS_RST = COL_W'(1024);
  localparam logic [ROW_W-1:0] ROWS_RST = ROW_W'(1024);
  localparam logic [H_W-1:0]   H_RST    = H_W'(4088);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLS      = 2'd0,
    CFG_ROWS      = 2'd1,
    CFG_H_PRODUCT = 2'd2
  } cfg_idx_t;

  typedef logic signed [DATA_W-1:0] data_t;

endpackage : jss_pkg

`default_nettype wire

>>> hw/rtl/jacobi_stencil_sweep_core.sv
// ============================================================================
// jacobi_stencil_sweep_core : 5-point Jacobi sweep on a raster stream
// Consumes the padded (rows+2) x (cols+2) frame one point per transaction and
// returns one updated value per interior point, saturated Q16.16.
// ============================================================================
//
//  Channel  Ports                                        Direction  Meaning
//  -------  -------------------------------------------  ---------  ---------------------
//  in       in_valid/in_stall, in_a_value, in_f_value,   sink       one padded frame point
//           in_frame_start
//  out      out_valid/out_stall, out_b_value, out_row,   source     one interior result
//           out_col, out_last_of_frame
//  cfg      cfg_we, cfg_index, cfg_data                  sink       cols, rows, h_product
//
//  One transaction per cycle sustained while out_stall is low. A result passes
//  the A, P and B registers after the transaction that completes its stencil
//  is taken (line RAM read, multiply/sum, round/saturate).
//  Line buffers are two RAMs of MAX_COLS+2 entries: the middle line with two
//  read ports (center and right column), the upper/source line with one.
//  No clearing pass after reset: line entries are only read once written.
//  out_stall backs up through the pipeline into in_stall in the same cycle.
//
`default_nettype none

module jacobi_stencil_sweep_core #(
  parameter int MAX_COLS = jss_pkg::MAX_COLS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,

  input  wire logic                              in_valid,
  output      logic                              in_stall,
  input  wire logic signed [jss_pkg::DATA_W-1:0] in_a_value,
  input  wire logic signed [jss_pkg::DATA_W-1:0] in_f_value,
  input  wire logic                              in_frame_start,

  output      logic                              out_valid,
  input  wire logic                              out_stall,
  output      logic signed [jss_pkg::DATA_W-1:0] out_b_value,
  output      logic [jss_pkg::OUT_ROW_W-1:0]     out_row,
  output      logic [jss_pkg::OUT_COL_W-1:0]     out_col,
  output      logic                              out_last_of_frame,

  input  wire logic                              cfg_we,
  input  wire logic [jss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [jss_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import jss_pkg::*;

  // --------------------------------------------------------------------------
  // Derived sizes
  // --------------------------------------------------------------------------
  localparam int LineDepth = MAX_COLS + 2;
  localparam int AW        = $clog2(LineDepth);
  // cols register is 11 bits, so the usable column count tops out at 2047
  localparam int ColCap    = (MAX_COLS < 2047) ? MAX_COLS : 2047;
  // column positions never pass 2047, so writes are bounded by either limit
  localparam int WrLim     = (LineDepth < 2048) ? LineDepth : 2048;
  localparam int SUM_W     = DATA_W + 2;   // sum of four neighbors
  localparam int D_W       = SUM_W + 2;    // sum minus product term, plus rounding

  localparam logic [COL_W-1:0] COL_CAP = COL_W'(ColCap);
  localparam logic [COL_W:0]   WR_LIM  = (COL_W + 1)'(WrLim);
  localparam logic [ROW_W-1:0] ROW_CAP = ROW_W'(ROW_LIMIT);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [COL_W-1:0] cols_r;
  logic [ROW_W-1:0] rows_r;
  logic [H_W-1:0]   h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLS_RST;
      rows_r <= ROWS_RST;
      h_r    <= H_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLS:      cols_r <= cfg_data[COL_W-1:0];
        CFG_ROWS:      rows_r <= cfg_data[ROW_W-1:0];
        CFG_H_PRODUCT: h_r    <= cfg_data[H_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size: zero acts as one, too large clamps to the cap
  logic [COL_W-1:0] nc;
  logic [ROW_W-1:0] nr;

  always_comb begin
    if (cols_r == '0)          nc = COL_W'(1);
    else if (cols_r > COL_CAP) nc = COL_CAP;
    else                       nc = cols_r;
    if (rows_r == '0)          nr = ROW_W'(1);
    else if (rows_r > ROW_CAP) nr = ROW_CAP;
    else                       nr = rows_r;
  end

  // --------------------------------------------------------------------------
  // Handshake / pipeline control
  //   A : line RAM read data + input point      (stencil sum, multiply)
  //   P : sum and product                       (round, saturate)
  //   B : output register
  // Points without a result retire from A (line write only) and skip P/B.
  // --------------------------------------------------------------------------
  logic a_vld_r, p_vld_r, b_vld_r;
  logic a_res_r;
  logic b_ld_ok, p_ok, adv_a, a_leave, accept;

  assign b_ld_ok  = !b_vld_r || !out_stall;
  assign p_ok     = !p_vld_r || b_ld_ok;
  assign adv_a    = !a_res_r || p_ok;
  assign in_stall = a_vld_r && !adv_a;
  assign a_leave  = a_vld_r && adv_a;
  assign accept   = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // Frame position, tracked at the input
  // --------------------------------------------------------------------------
  logic [COL_W-1:0] col_pos_r;
  logic [ROW_W-1:0] row_pos_r;
  logic [COL_W-1:0] cur_pc, col_nxt;
  logic [ROW_W-1:0] cur_pr, row_nxt;
  logic [COL_W:0]   pc_inc, nc_p2;
  logic [ROW_W:0]   pr_inc, nr_p1, nr_p2;
  logic             col_wrap, in_res, in_last;
  logic [ROW_W-1:0] row_m2;
  logic [COL_W-1:0] col_m1;

  always_comb begin
    cur_pc   = in_frame_start ? '0 : col_pos_r;
    cur_pr   = in_frame_start ? '0 : row_pos_r;
    pc_inc   = {1'b0, cur_pc} + (COL_W + 1)'(1);
    nc_p2    = {1'b0, nc} + (COL_W + 1)'(2);
    pr_inc   = {1'b0, cur_pr} + (ROW_W + 1)'(1);
    nr_p1    = {1'b0, nr} + (ROW_W + 1)'(1);
    nr_p2    = {1'b0, nr} + (ROW_W + 1)'(2);
    col_wrap = (pc_inc >= nc_p2);

    col_nxt = col_wrap ? '0 : pc_inc[COL_W-1:0];
    if (!col_wrap)          row_nxt = cur_pr;
    else if (pr_inc >= nr_p2) row_nxt = '0;
    else                    row_nxt = pr_inc[ROW_W-1:0];

    // interior point whose stencil completes with this transaction
    in_res  = (cur_pr >= ROW_W'(2)) && ({1'b0, cur_pr} <= nr_p1) &&
              (cur_pc != '0) && (cur_pc <= nc);
    in_last = ({1'b0, cur_pr} == nr_p1) && (cur_pc == nc);
    row_m2  = cur_pr - ROW_W'(2);
    col_m1  = cur_pc - COL_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r <= '0;
      row_pos_r <= '0;
    end else if (accept) begin
      col_pos_r <= col_nxt;
      row_pos_r <= row_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage A registers
  // --------------------------------------------------------------------------
  data_t                a_a_r, a_f_r;
  logic [COL_W-1:0]     a_pc_r;
  logic [OUT_ROW_W-1:0] a_row_r;
  logic [OUT_COL_W-1:0] a_col_r;
  logic                 a_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      a_res_r <= 1'b0;
    end else if (accept) begin
      a_vld_r <= 1'b1;
      a_res_r <= in_res;
    end else if (a_leave) begin
      a_vld_r <= 1'b0;
      a_res_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_a_r    <= in_a_value;
      a_f_r    <= in_f_value;
      a_pc_r   <= cur_pc;
      a_row_r  <= row_m2[OUT_ROW_W-1:0];
      a_col_r  <= col_m1[OUT_COL_W-1:0];
      a_last_r <= in_last;
    end
  end

  // --------------------------------------------------------------------------
  // Line buffers
  //   mid_mem : previous row values            (read at col and col+1)
  //   us_mem  : {row before that, source of previous row}   (read at col)
  // The point in A writes when it retires; a read issued on the same edge at
  // the same address takes the write data instead (bypass).
  // --------------------------------------------------------------------------
  logic [DATA_W-1:0]   mid_mem [LineDepth];
  logic [2*DATA_W-1:0] us_mem  [LineDepth];

  logic [DATA_W-1:0]   mid0_r, mid1_r, byp_mid_r;
  logic [2*DATA_W-1:0] us_r, byp_us_r;
  logic                hit0_r, hit1_r;
  logic [DATA_W-1:0]   a_mid0, a_mid1;
  logic [2*DATA_W-1:0] a_us, wr_us;
  logic                wr_en;
  logic [AW-1:0]       wr_addr, rd_addr0, rd_addr1;

  assign a_mid0   = hit0_r ? byp_mid_r : mid0_r;
  assign a_mid1   = hit1_r ? byp_mid_r : mid1_r;
  assign a_us     = hit0_r ? byp_us_r  : us_r;
  assign wr_us    = {a_mid0, a_f_r};
  assign wr_en    = a_leave && ({1'b0, a_pc_r} < WR_LIM);
  assign wr_addr  = AW'(a_pc_r);
  assign rd_addr0 = AW'(cur_pc);
  assign rd_addr1 = AW'(pc_inc);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mid_mem[wr_addr] <= a_a_r;
      us_mem[wr_addr]  <= wr_us;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mid0_r    <= mid_mem[rd_addr0];
      mid1_r    <= mid_mem[rd_addr1];
      us_r      <= us_mem[rd_addr0];
      hit0_r    <= wr_en && (a_pc_r == cur_pc);
      hit1_r    <= wr_en && ({1'b0, a_pc_r} == pc_inc);
      byp_mid_r <= a_a_r;
      byp_us_r  <= wr_us;
    end
  end

  // Left neighbor: the previous point's old middle-line value, which is what
  // the upper line holds at col-1 after that point retired.
  logic [DATA_W-1:0] left_r;

  always_ff @(posedge clk) begin
    if (a_leave) begin
      left_r <= a_mid0;
    end
  end

  // --------------------------------------------------------------------------
  // Stage A -> P : neighbor sum and h_product * f
  // --------------------------------------------------------------------------
  data_t                     a_up, a_src;
  logic signed [SUM_W-1:0]   a_sum;
  logic signed [DATA_W+H_W:0] a_prod;

  always_comb begin
    a_up   = $signed(a_us[2*DATA_W-1:DATA_W]);
    a_src  = $signed(a_us[DATA_W-1:0]);
    a_sum  = SUM_W'(a_up) + SUM_W'(a_a_r) + SUM_W'($signed(left_r)) +
             SUM_W'($signed(a_mid1));
    a_prod = a_src * $signed({1'b0, h_r});
  end

  logic signed [SUM_W-1:0]  p_sum_r;
  data_t                    p_ph_r;
  logic                     p_nz_r;
  logic [OUT_ROW_W-1:0]     p_row_r;
  logic [OUT_COL_W-1:0]     p_col_r;
  logic                     p_last_r;
  logic                     p_ld;

  assign p_ld = a_leave && a_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (p_ld) begin
      p_vld_r <= 1'b1;
    end else if (b_ld_ok) begin
      p_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_ld) begin
      p_sum_r  <= a_sum;
      p_ph_r   <= $signed(a_prod[DATA_W+H_W-1:H_W]);   // floor of product / 2^32
      p_nz_r   <= |a_prod[H_W-1:0];
      p_row_r  <= a_row_r;
      p_col_r  <= a_col_r;
      p_last_r <= a_last_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage P -> B : (sum - ceil(prod/2^32) + 2) >> 2, then saturate
  // --------------------------------------------------------------------------
  logic [D_W-1:0]   p_d;
  logic [SUM_W-1:0] p_q;
  data_t            p_b;

  always_comb begin
    p_d = {{2{p_sum_r[SUM_W-1]}}, p_sum_r}
        - {{(D_W - DATA_W){p_ph_r[DATA_W-1]}}, p_ph_r}
        - {{(D_W - 1){1'b0}}, p_nz_r}
        + D_W'(2);
    p_q = p_d[D_W-1:2];
    // overflow when the bits above the result sign disagree with it
    if (p_q[SUM_W-1:DATA_W-1] == '0 || p_q[SUM_W-1:DATA_W-1] == '1) begin
      p_b = $signed(p_q[DATA_W-1:0]);
    end else if (p_q[SUM_W-1]) begin
      p_b = $signed({1'b1, {(DATA_W - 1){1'b0}}});
    end else begin
      p_b = $signed({1'b0, {(DATA_W - 1){1'b1}}});
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic b_ld;

  assign b_ld = p_vld_r && b_ld_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (b_ld) begin
      b_vld_r <= 1'b1;
    end else if (!out_stall) begin
      b_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ld) begin
      out_b_value       <= p_b;
      out_row           <= p_row_r;
      out_col           <= p_col_r;
      out_last_of_frame <= p_last_r;
    end
  end

  assign out_valid = b_vld_r;

endmodule : jacobi_stencil_sweep_core

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top : regression for jacobi_stencil_sweep_core
// Streams padded frames through the core and predicts every interior update.
// Each update that comes out is compared against the queued prediction:
// value, row, column and end-of-frame flag. Covers register corner values,
// saturation, frame wrap, cut-short frames, mid-frame resizes, back-pressure
// and a long randomized phase with random idling on both channels.
// ============================================================================

module tb_top;
  import jss_pkg::*;

  localparam int MAX_COLS       = MAX_COLS_DEF;
  localparam int LINE_DEPTH     = MAX_COLS + 2;
  localparam int WATCHDOG_LIMIT = 2000;  // longest legal quiet stretch is the HOLD_OFF hold
  localparam int PIPE_SETTLE    = 8;     // margin past the core's A, P and B registers for halo-only tails
  localparam int RANDOM_POINTS  = 300;
  localparam int HOLD_OFF       = 300;
  localparam int BIG_FRAME_CUT  = 24;    // points sent of a frame too large to run whole

  localparam data_t Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // One interior update as the core reports it
  typedef struct packed {
    data_t                b_value;
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
    logic                 last;
  } grid_update_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_stall;
  data_t                 in_a_value     = '0;
  data_t                 in_f_value     = '0;
  logic                  in_frame_start = 1'b0;
  logic                  out_valid;
  logic                  out_stall      = 1'b0;
  data_t                 out_b_value;
  logic [OUT_ROW_W-1:0]  out_row;
  logic [OUT_COL_W-1:0]  out_col;
  logic                  out_last_of_frame;
  logic                  cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = CFG_COLS;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;

  // --------------------------------------------------------------------------
  // Predictor state: register shadows, three line buffers, raster position
  // --------------------------------------------------------------------------
  logic [COL_W-1:0] cols_reg = COLS_RST;
  logic [ROW_W-1:0] rows_reg = ROWS_RST;
  logic [H_W-1:0]   h_reg    = H_RST;
  data_t            north_line  [LINE_DEPTH];  // row above the current one
  data_t            center_line [LINE_DEPTH];  // current row (previous pass)
  data_t            rhs_line    [LINE_DEPTH];  // source term of the center row
  int               pos_row = 0;
  int               pos_col = 0;
  grid_update_t     expected_updates [$];

  // Stimulus knobs and bookkeeping
  bit tx_jitter      = 1'b0;
  bit rx_jitter      = 1'b0;
  int rx_hold_cycles = 0;
  int errors         = 0;
  int points_sent    = 0;
  int updates_seen   = 0;
  int sat_high       = 0;
  int sat_low        = 0;
  int cut_frames     = 0;
  int stall_cycles   = 0;
  int idle_cycles    = 0;

  always #2 clk = ~clk;

  jacobi_stencil_sweep_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_a_value        (in_a_value),
    .in_f_value        (in_f_value),
    .in_frame_start    (in_frame_start),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_b_value       (out_b_value),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_last_of_frame (out_last_of_frame),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  // Out-of-range register values clamp: 0 acts as 1, oversize acts as the limit.
  function automatic int active_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > MAX_COLS) return MAX_COLS;
    return int'(cols_reg);
  endfunction

  function automatic int active_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > ROW_LIMIT) return ROW_LIMIT;
    return int'(rows_reg);
  endfunction

  function automatic int padded_points();
    return (active_rows() + 2) * (active_cols() + 2);
  endfunction

  // (sum * 2^32 - h * f) / 2^34, rounded half up, clipped to Q16.16.
  // 72 bits hold the shifted neighbour sum without overflow.
  function automatic data_t relax_value(longint nsum, data_t f);
    logic signed [71:0] acc;
    acc = (72'(nsum) <<< 32) - 72'(longint'(f) * longint'({1'b0, h_reg}));
    acc = (acc + (72'sd1 <<< 33)) >>> 34;
    if (acc > 72'(Q_MAX)) begin
      sat_high++;
      return Q_MAX;
    end
    if (acc < 72'(Q_MIN)) begin
      sat_low++;
      return Q_MIN;
    end
    return data_t'(acc[DATA_W-1:0]);
  endfunction

  // Advances the raster by one accepted point. The update for interior (r,c)
  // becomes known at padded point (r+2, c+1), where its south neighbour lands.
  function automatic void sweep_point(data_t a, data_t f, logic start);
    int           nc;
    int           nr;
    int           pr;
    int           pc;
    longint       nsum;
    grid_update_t upd;
    nc = active_cols();
    nr = active_rows();
    if (start) begin
      pos_row = 0;
      pos_col = 0;
    end
    pr = pos_row;
    pc = pos_col;
    if (pr >= 2 && pr <= nr + 1 && pc >= 1 && pc <= nc) begin
      // north, south (incoming), west (already shifted this row), east
      nsum = longint'(north_line[pc]) + longint'(a) + longint'(north_line[pc-1])
           + longint'(center_line[pc+1]);
      upd.b_value = relax_value(nsum, rhs_line[pc]);
      upd.row     = OUT_ROW_W'(pr - 2);
      upd.col     = OUT_COL_W'(pc - 1);
      upd.last    = (pr == nr + 1) && (pc == nc);
      expected_updates.push_back(upd);
    end
    if (pc < LINE_DEPTH) begin
      north_line[pc]  = center_line[pc];
      center_line[pc] = a;
      rhs_line[pc]    = f;
    end
    pc++;
    // wrap on reaching or passing the edge, so a shrunk frame still closes
    if (pc >= nc + 2) begin
      pc = 0;
      pr++;
      if (pr >= nr + 2) pr = 0;
    end
    pos_row = pr & ((1 << ROW_W) - 1);
    pos_col = pc & ((1 << COL_W) - 1);
  endfunction

  // Mix of extremes, small values near zero and full-range noise
  function automatic data_t draw_value();
    case ($urandom_range(0, 7))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2, 3:    return data_t'($urandom_range(0, 32'h0003_ffff)) - 32'sh0002_0000;
      default: return data_t'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Input channel
  // --------------------------------------------------------------------------
  // Valid stays up across back-to-back points; it only drops for a real gap.
  task automatic send_point(input data_t a, input data_t f, input logic start);
    int gap;
    gap = tx_jitter ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_a_value     <= a;
    in_f_value     <= f;
    in_frame_start <= start;
    do @(posedge clk); while (in_stall);
    sweep_point(a, f, start);
    points_sent++;
  endtask

  task automatic send_frame(input int n_points, input logic start);
    for (int i = 0; i < n_points; i++) send_point(draw_value(), draw_value(), start && i == 0);
  endtask

  // Stop offering and wait for every predicted update, then let the pipe settle
  task automatic wait_for_updates(input int settle);
    in_valid <= 1'b0;
    while (expected_updates.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Writes all three registers on consecutive cycles, only once the core is idle.
  // Bits above each register's width carry noise; the core must drop them.
  task automatic program_grid(input logic [COL_W-1:0] c, input logic [ROW_W-1:0] r,
                              input logic [H_W-1:0] h);
    wait_for_updates(PIPE_SETTLE);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_COLS;
    cfg_data  <= ($urandom & ~32'h0000_07ff) | CFG_DATA_W'(c);
    @(posedge clk);
    cfg_index <= CFG_ROWS;
    cfg_data  <= ($urandom & ~32'h0000_1fff) | CFG_DATA_W'(r);
    @(posedge clk);
    cfg_index <= CFG_H_PRODUCT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cols_reg  = c;
    rows_reg  = r;
    h_reg     = h;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset registers: 1024 columns. The start of the first padded row gives no
  // update; a narrower reset width would wrap early and produce some.
  task automatic test_reset_defaults();
    tx_jitter = 1'b0;
    rx_jitter = 1'b1;
    send_frame(BIG_FRAME_CUT, 1'b1);
    cut_frames++;
  endtask

  // 1x1 interior, h at full scale: clip high, clip low via wrap (no start
  // flag), then a frame cut short by a start flag.
  task automatic test_value_extremes();
    program_grid(11'd1, 13'd1, '1);
    tx_jitter = 1'b1;
    rx_jitter = 1'b1;
    for (int i = 0; i < 9; i++) send_point(Q_MAX, Q_MIN, i == 0);
    for (int i = 0; i < 9; i++) send_point(Q_MIN, Q_MAX, 1'b0);
    send_frame(4, 1'b1);
    cut_frames++;
    send_frame(9, 1'b1);
  endtask

  // Register corners: zero sizes, oversize columns, oversize rows, h = 0
  task automatic test_register_extremes();
    program_grid(11'd0, 13'd0, '0);
    tx_jitter = 1'b1;
    rx_jitter = 1'b1;
    send_frame(padded_points(), 1'b1);
    // big frames run only their first rows to keep the run short
    tx_jitter = 1'b0;
    rx_jitter = 1'b0;
    program_grid(11'd2047, 13'd1, $urandom);
    send_frame(BIG_FRAME_CUT, 1'b1);
    cut_frames++;
    program_grid(11'd1, 13'd8191, $urandom);
    send_frame(30, 1'b1);
    cut_frames++;
  endtask

  // Resize while the raster sits mid-frame. Every line entry a stencil reads
  // was written earlier in the same frame.
  task automatic test_midframe_resize();
    program_grid(11'd8, 13'd6, $urandom);
    tx_jitter = 1'b1;
    rx_jitter = 1'b1;
    send_frame(35, 1'b1);               // parks at padded (3,5)
    program_grid(11'd2, 13'd6, h_reg);  // column already past the new edge
    send_frame(10, 1'b0);               // parks at padded (6,1)
    program_grid(11'd2, 13'd1, h_reg);  // row already past the new edge
    send_frame(15, 1'b0);               // finish the row, then one whole frame
    send_frame(padded_points(), 1'b1);
  endtask

  // Receiver holds off long enough for the core to fill and stall its input;
  // partway through, the sender also pauses until everything has drained.
  task automatic test_backpressure();
    program_grid(11'd16, 13'd4, $urandom);
    tx_jitter      = 1'b0;
    rx_jitter      = 1'b0;
    rx_hold_cycles = HOLD_OFF;
    send_frame(60, 1'b1);
    wait_for_updates(0);
    send_frame(padded_points() - 60, 1'b0);
  endtask

  // Mostly well-formed frames with random content and sizes; some frames
  // are cut short, some carry a redundant start flag, some follow by wrap.
  task automatic test_random_frames();
    int               first_point;
    int               total;
    bit               need_start;
    logic [COL_W-1:0] c;
    logic [ROW_W-1:0] r;
    logic [H_W-1:0]   h;
    first_point = points_sent;
    while (points_sent - first_point < RANDOM_POINTS) begin
      case ($urandom_range(0, 5))
        0:       c = '0;
        1, 2:    c = COL_W'($urandom_range(1, 4));
        3, 4:    c = COL_W'($urandom_range(5, 12));
        default: c = COL_W'($urandom_range(13, 30));
      endcase
      r = ($urandom_range(0, 7) == 0) ? '0 : ROW_W'($urandom_range(1, 6));
      case ($urandom_range(0, 3))
        0:       h = '0;
        1:       h = '1;
        2:       h = $urandom_range(0, 16'hffff);
        default: h = $urandom;
      endcase
      program_grid(c, r, h);
      tx_jitter  = ($urandom_range(0, 3) != 0);
      rx_jitter  = ($urandom_range(0, 3) != 0);
      need_start = 1'b1;
      repeat ($urandom_range(1, 3)) begin
        if (points_sent - first_point >= RANDOM_POINTS) break;
        total = padded_points();
        if ($urandom_range(0, 5) == 0) begin
          send_frame($urandom_range(1, total - 1), need_start || $urandom_range(0, 1));
          need_start = 1'b1;
          cut_frames++;
        end else begin
          send_frame(total, need_start || ($urandom_range(0, 3) == 0));
          need_start = 1'b0;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Output channel: stall pattern plus the update checker
  // --------------------------------------------------------------------------
  initial begin : update_checker
    int           stall_left;
    grid_update_t want;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        updates_seen++;
        if (expected_updates.size() == 0) begin
          errors++;
          $display("%0t: unexpected update b=%h row=%0d col=%0d last=%b", $time,
                   out_b_value, out_row, out_col, out_last_of_frame);
        end else begin
          want = expected_updates.pop_front();
          if (out_b_value !== want.b_value) begin
            errors++;
            $display("%0t: b_value at (%0d,%0d) expected %h, got %h", $time,
                     want.row, want.col, want.b_value, out_b_value);
          end
          if (out_row !== want.row) begin
            errors++;
            $display("%0t: out_row expected %0d, got %0d", $time, want.row, out_row);
          end
          if (out_col !== want.col) begin
            errors++;
            $display("%0t: out_col expected %0d, got %0d", $time, want.col, out_col);
          end
          if (out_last_of_frame !== want.last) begin
            errors++;
            $display("%0t: last_of_frame at (%0d,%0d) expected %b, got %b", $time,
                     want.row, want.col, want.last, out_last_of_frame);
          end
        end
        stall_left = rx_jitter ? $urandom_range(0, 9) : 0;
      end
      // long hold-off takes priority over the per-transaction jitter
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: any accepted transaction on either channel rearms it
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (in_valid && in_stall) stall_cycles <= stall_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d updates outstanding", $time,
               idle_cycles, expected_updates.size());
      $display("jacobi_stencil_sweep_core regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_value_extremes();
    test_register_extremes();
    test_midframe_resize();
    test_backpressure();
    test_random_frames();
    wait_for_updates(PIPE_SETTLE);
    $display("Swept %0d grid points into %0d checked updates (%0d clipped high, %0d low).",
             points_sent, updates_seen, sat_high, sat_low);
    $display("Input held off for %0d cycles, %0d frames cut short, %0d mismatches.",
             stall_cycles, cut_frames, errors);
    if (errors == 0) begin
      $display("jacobi_stencil_sweep_core regression: pass");
    end else begin
      $display("jacobi_stencil_sweep_core regression: fail");
    end
    $finish;
  end

endmodule
